### rtl/core/chained_hash_key_table_macros.svh
// Assertion macros used by the checker file of the hash key table.
`ifndef CHAINED_HASH_KEY_TABLE_MACROS_SVH
`define CHAINED_HASH_KEY_TABLE_MACROS_SVH

// Concurrent assertion sampled on clk and held off while arst_n is low.
`define CHKT_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// When cond holds, held must hold in the following cycle.
`define CHKT_ASSERT_NEXT(label, cond, held, msg) \
	`CHKT_ASSERT(label, (cond) |=> (held), msg)

`endif

### rtl/core/chkt_pkg.sv
// Shared types, sizes and codes of the chained hash key table.
package chkt_pkg;

	localparam int BUCKETS          = 16;
	localparam int SLOTS_PER_BUCKET = 8;
	localparam int KEY_W            = 31;
	localparam int BUCKET_W         = $clog2(BUCKETS);
	localparam int SLOT_W           = $clog2(SLOTS_PER_BUCKET);
	localparam int MOD_W            = 5;
	localparam int CNT_W            = $clog2(KEY_W);
	localparam int OP_W             = 2;
	localparam int STATUS_W         = 2;
	localparam int S_TDATA_W        = 32;
	localparam int M_TDATA_W        = 8;

	localparam logic [MOD_W-1:0] BUCKET_COUNT_RESET = MOD_W'(BUCKETS);

	localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
	localparam logic [OP_W-1:0] OP_SEARCH = 2'd1;
	localparam logic [OP_W-1:0] OP_DELETE = 2'd2;

	localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;

	typedef logic [KEY_W-1:0] key_t;
	typedef logic [SLOTS_PER_BUCKET-1:0][KEY_W-1:0] key_row_t;
	typedef logic [SLOTS_PER_BUCKET-1:0] valid_row_t;

	typedef struct packed {
		logic                done;
		logic [BUCKET_W-1:0] rem;
	} mod_res_t;

endpackage

### rtl/core/chkt_mod_unit.sv
// Bit-serial restoring remainder unit: key modulo the bucket count, one key bit per cycle.
module chkt_mod_unit (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  chkt_pkg::key_t          key,
	input  logic [chkt_pkg::MOD_W-1:0] modulus,
	output chkt_pkg::mod_res_t      res
);
	import chkt_pkg::*;

	logic                busy_q;
	logic                done_q;
	logic [CNT_W-1:0]    cnt_q;
	key_t                dividend_q;
	logic [MOD_W-1:0]    mod_q;
	logic [BUCKET_W-1:0] rem_q;
	logic [BUCKET_W:0]   shifted;
	logic [BUCKET_W-1:0] rem_next;

	// The partial remainder stays below the modulus, so one subtract per bit suffices.
	always_comb begin
		shifted = {rem_q, dividend_q[KEY_W-1]};
		if ({1'b0, shifted} >= {1'b0, mod_q}) begin
			rem_next = BUCKET_W'(shifted - (BUCKET_W+1)'(mod_q));
		end else begin
			rem_next = shifted[BUCKET_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(KEY_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dividend_q <= key;
			mod_q      <= modulus;
			rem_q      <= '0;
		end else if (busy_q) begin
			dividend_q <= {dividend_q[KEY_W-2:0], 1'b0};
			rem_q      <= rem_next;
		end
	end

	assign res.done = done_q;
	assign res.rem  = rem_q;

endmodule

### rtl/core/chkt_key_ram.sv
// Key store: one row of slot keys per bucket, synchronous read with a registered output.
module chkt_key_ram (
	input  logic                          clk,
	input  logic                          wr_en,
	input  logic [chkt_pkg::BUCKET_W-1:0] wr_addr,
	input  chkt_pkg::key_row_t            wr_data,
	input  logic                          rd_en,
	input  logic [chkt_pkg::BUCKET_W-1:0] rd_addr,
	output chkt_pkg::key_row_t            rd_data
);
	import chkt_pkg::*;

	key_row_t mem [BUCKETS];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

### rtl/core/chained_hash_key_table.sv
// Top level of the chained hash key table: request sequencer, slot valid bits and result register.
//
//   channel   dir  handshake           payload
//   s_*       in   s_tvalid/s_tready   s_tuser = opcode, s_tdata = key
//   m_*       out  m_tvalid/m_tready   m_tuser = status, m_tdata = bucket_index
//   cfg_*     in   cfg_wr_en           cfg_wr_data = bucket_count
//
// A request passes from acceptance to a valid result through the bit-serial remainder
// unit (one key bit per cycle), a step that latches the bucket index, the bucket row
// read from the key memory and a step for compare and write back. The next request
// is taken in the cycle after write back, so a new request is not taken before the
// last one has been written back.
// Reset clears every slot valid bit at once, so the table is empty right after reset.
// One request is in flight at a time; a finished result waits in the output register
// while the next request is taken, and only a full output register stalls write back.
module chained_hash_key_table (
	input  logic                             clk,
	input  logic                             arst_n,
	// Request stream.
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [chkt_pkg::S_TDATA_W-1:0]   s_tdata,  // [30:0] key, [31] ignored
	input  logic [chkt_pkg::OP_W-1:0]        s_tuser,  // [1:0] opcode
	// Result stream.
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [chkt_pkg::M_TDATA_W-1:0]   m_tdata,  // [3:0] bucket_index, [7:4] zero
	output logic [chkt_pkg::STATUS_W-1:0]    m_tuser,  // [1:0] status
	// Bucket count register.
	input  logic                             cfg_wr_en,
	input  logic [chkt_pkg::MOD_W-1:0]       cfg_wr_data
);
	import chkt_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_DIV  = 4'b0010,
		S_READ = 4'b0100,
		S_CMP  = 4'b1000
	} state_t;

	state_t state_q;

	logic [MOD_W-1:0]    bucket_count_q;
	logic [MOD_W-1:0]    modulus;
	logic [OP_W-1:0]     op_q;
	key_t                key_q;
	logic [BUCKET_W-1:0] bucket_q;

	valid_row_t          valid_q [BUCKETS];

	logic                out_valid_q;
	logic [STATUS_W-1:0] out_status_q;
	logic [BUCKET_W-1:0] out_bucket_q;

	logic                accept;
	mod_res_t            mod_res;
	key_row_t            rd_row;
	key_row_t            wr_row;
	logic                cmp_fire;

	// Compare results over the bucket row.
	valid_row_t          row_valid;
	logic                match_any;
	logic [SLOT_W-1:0]   match_idx;
	logic                free_any;
	logic [SLOT_W-1:0]   free_idx;
	logic                do_write_key;
	logic                do_set_valid;
	logic                do_clr_valid;
	logic [STATUS_W-1:0] res_status;
	logic [BUCKET_W-1:0] res_bucket;

	assign s_tready = (state_q == S_IDLE);
	assign accept   = s_tvalid && s_tready;

	// A bucket count of zero acts as one; anything above the table size is clamped.
	always_comb begin
		if (bucket_count_q == '0) begin
			modulus = MOD_W'(1);
		end else if (bucket_count_q > MOD_W'(BUCKETS)) begin
			modulus = MOD_W'(BUCKETS);
		end else begin
			modulus = bucket_count_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bucket_count_q <= BUCKET_COUNT_RESET;
		end else if (cfg_wr_en) begin
			bucket_count_q <= cfg_wr_data;
		end
	end

	chkt_mod_unit u_mod (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (accept),
		.key     (s_tdata[KEY_W-1:0]),
		.modulus (modulus),
		.res     (mod_res)
	);

	chkt_key_ram u_ram (
		.clk     (clk),
		.wr_en   (do_write_key),
		.wr_addr (bucket_q),
		.wr_data (wr_row),
		.rd_en   (state_q == S_READ),
		.rd_addr (bucket_q),
		.rd_data (rd_row)
	);

	// First matching slot and first free slot of the addressed bucket. Slots that are
	// not valid never match, so stale or unwritten keys are never looked at.
	always_comb begin
		row_valid = valid_q[bucket_q];
		match_any = 1'b0;
		match_idx = '0;
		free_any  = 1'b0;
		free_idx  = '0;
		for (int s = SLOTS_PER_BUCKET - 1; s >= 0; s--) begin
			if (row_valid[s] && (rd_row[s] == key_q)) begin
				match_any = 1'b1;
				match_idx = SLOT_W'(s);
			end
			if (!row_valid[s]) begin
				free_any = 1'b1;
				free_idx = SLOT_W'(s);
			end
		end
	end

	// Write back happens once the output register can take the result.
	assign cmp_fire = (state_q == S_CMP) && (!out_valid_q || m_tready);

	always_comb begin
		do_write_key = 1'b0;
		do_set_valid = 1'b0;
		do_clr_valid = 1'b0;
		res_status   = ST_NOT_FOUND;
		res_bucket   = '0;
		wr_row       = rd_row;
		wr_row[free_idx] = key_q;
		unique case (op_q) inside
			OP_INSERT: begin
				res_bucket = bucket_q;
				if (free_any) begin
					res_status   = ST_OK;
					do_write_key = cmp_fire;
					do_set_valid = cmp_fire;
				end else begin
					res_status = ST_FULL;
				end
			end
			OP_SEARCH, OP_DELETE: begin
				if (match_any) begin
					res_status   = ST_OK;
					res_bucket   = bucket_q;
					do_clr_valid = cmp_fire && (op_q == OP_DELETE);
				end
			end
			default: begin
				res_status = ST_NOT_FOUND;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int b = 0; b < BUCKETS; b++) begin
				valid_q[b] <= '0;
			end
		end else if (do_set_valid) begin
			valid_q[bucket_q][free_idx] <= 1'b1;
		end else if (do_clr_valid) begin
			valid_q[bucket_q][match_idx] <= 1'b0;
		end
	end

	// Request sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: if (accept)       state_q <= S_DIV;
				S_DIV:  if (mod_res.done) state_q <= S_READ;
				S_READ: state_q <= S_CMP;
				S_CMP:  if (cmp_fire)     state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q  <= s_tuser;
			key_q <= s_tdata[KEY_W-1:0];
		end
		if ((state_q == S_DIV) && mod_res.done) begin
			bucket_q <= mod_res.rem;
		end
	end

	// Output register: holds a finished result until the sink takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmp_fire) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmp_fire) begin
			out_status_q <= res_status;
			out_bucket_q <= res_bucket;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_status_q;
	assign m_tdata  = M_TDATA_W'(out_bucket_q);

endmodule

### rtl/core/chkt_checker.sv
// Port-level checker of the chained hash key table and its bind to the top level.
`include "chained_hash_key_table_macros.svh"

module chkt_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           s_tvalid,
	input logic                           s_tready,
	input logic                           m_tvalid,
	input logic                           m_tready,
	input logic [chkt_pkg::M_TDATA_W-1:0] m_tdata,
	input logic [chkt_pkg::STATUS_W-1:0]  m_tuser
);
	import chkt_pkg::*;

	// A result that is not taken stays offered and unchanged.
	`CHKT_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid, "result dropped while stalled")
	`CHKT_ASSERT_NEXT(a_out_stable, m_tvalid && !m_tready, $stable(m_tdata) && $stable(m_tuser), "stalled result changed")

	// A lookup miss reports bucket zero, and no unused status code is produced.
	`CHKT_ASSERT(a_miss_zero, m_tvalid && (m_tuser == ST_NOT_FOUND) |-> (m_tdata == '0), "miss with nonzero bucket")
	`CHKT_ASSERT(a_status_code, m_tvalid |-> (m_tuser == ST_OK) || (m_tuser == ST_NOT_FOUND) || (m_tuser == ST_FULL), "bad status code")

	// A request accepted now cannot already be answered in the next cycle.
	`CHKT_ASSERT_NEXT(a_no_early, s_tvalid && s_tready && !m_tvalid, !m_tvalid, "result too early")

endmodule

bind chained_hash_key_table chkt_checker u_chkt_checker (.*);
